[rtl/mfp_pkg.sv]
package mfp_pkg;

    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_CAP       = 9'd511;
    localparam logic [POS_W-1:0] POS_CLOSE_MIN = 9'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST = 9'd6;
    localparam logic [POS_W-1:0] POS_START2    = 9'd7;
    localparam logic [POS_W-1:0] POS_CTRL      = 9'd8;
    localparam logic [POS_W-1:0] POS_LEN       = 9'd9;
    localparam logic [POS_W-1:0] POS_DATA      = 9'd10;
    localparam logic [POS_W-1:0] POS_ID_END    = 9'd14;
    localparam logic [POS_W-1:0] POS_BCD_END   = 9'd16;

    localparam logic [7:0] START_BYTE  = 8'h68;
    localparam logic [7:0] CLOSE_BYTE  = 8'h16;
    localparam logic [7:0] DATA_OFFSET = 8'h33;
    localparam logic [7:0] ADDR_WILD   = 8'hAA;
    localparam logic [7:0] ERR_NO_ITEM = 8'h02;
    localparam int unsigned FOLLOW_BIT = 5;

    localparam logic [7:0] C_REPLY_A  = 8'h91;
    localparam logic [7:0] C_REPLY_B  = 8'hB1;
    localparam logic [7:0] C_FOLLOW_A = 8'h92;
    localparam logic [7:0] C_FOLLOW_B = 8'hB2;
    localparam logic [7:0] C_READ     = 8'h11;
    localparam logic [7:0] C_SEARCH   = 8'h13;
    localparam logic [7:0] C_TIME     = 8'h08;
    localparam logic [7:0] C_WRITE    = 8'h14;
    localparam logic [7:0] C_ABN_A    = 8'hD1;
    localparam logic [7:0] C_ABN_B    = 8'hD2;

    typedef enum logic [3:0] {
        TAG_PREAMBLE = 4'd0,
        TAG_START    = 4'd1,
        TAG_ADDR     = 4'd2,
        TAG_START2   = 4'd3,
        TAG_CTRL     = 4'd4,
        TAG_LEN      = 4'd5,
        TAG_ID       = 4'd6,
        TAG_DATA     = 4'd7,
        TAG_SEQ      = 4'd8,
        TAG_AFTER    = 4'd9
    } t_tag;

    typedef enum logic [3:0] {
        ST_REPLY       = 4'd0,
        ST_REPLY_SEQ   = 4'd1,
        ST_READ        = 4'd2,
        ST_ADDR_SEARCH = 4'd3,
        ST_CTRL13      = 4'd4,
        ST_TIME        = 4'd5,
        ST_WRITE       = 4'd6,
        ST_NO_ITEM     = 4'd7,
        ST_OTHER_ERR   = 4'd8,
        ST_UNSUPPORTED = 4'd9,
        ST_INVALID     = 4'd10
    } t_status;

    typedef struct packed {
        logic [7:0]  byte_value;
        t_tag        field_tag;
        logic [7:0]  bcd_binary;
        logic        frame_done;
        t_status     status;
        logic [7:0]  control_code;
        logic        follow_flag;
        logic [47:0] meter_address;
        logic [31:0] data_id;
        logic [7:0]  sequence_res;
        logic [7:0]  error_byte;
    } t_result;

    function automatic logic is_follow(input logic [7:0] c);
        return (c == C_FOLLOW_A) || (c == C_FOLLOW_B);
    endfunction

    function automatic logic has_data_id(input logic [7:0] c);
        return (c == C_REPLY_A) || (c == C_REPLY_B) || is_follow(c) ||
               (c == C_READ) || (c == C_WRITE);
    endfunction

    function automatic t_status frame_status(input logic ok, input logic [7:0] c,
                                             input logic all_aa, input logic [7:0] err);
        t_status st;
        st = ST_UNSUPPORTED;
        if (!ok) begin
            st = ST_INVALID;
        end else begin
            unique case (c)
                C_REPLY_A, C_REPLY_B:   st = ST_REPLY;
                C_FOLLOW_A, C_FOLLOW_B: st = ST_REPLY_SEQ;
                C_READ:                 st = ST_READ;
                C_SEARCH:               st = all_aa ? ST_ADDR_SEARCH : ST_CTRL13;
                C_TIME:                 st = ST_TIME;
                C_WRITE:                st = ST_WRITE;
                C_ABN_A, C_ABN_B:       st = (err == ERR_NO_ITEM) ? ST_NO_ITEM : ST_OTHER_ERR;
                default:                st = ST_UNSUPPORTED;
            endcase
        end
        return st;
    endfunction

endpackage

[rtl/mfp_core.sv]
module mfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_last,
    output mfp_pkg::t_result  o_result
);
    import mfp_pkg::*;

    logic             r_started, n_started;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_sum_prev, n_sum_prev;
    logic [7:0]       r_prev, n_prev;
    logic             r_hdr_ok, n_hdr_ok;
    logic             r_close_ok, n_close_ok;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [47:0]      r_addr, n_addr;
    logic [31:0]      r_id, n_id;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_err, n_err;
    logic             r_all_aa, n_all_aa;

    logic [POS_W-1:0] data_end;
    logic [POS_W-1:0] seq_pos;
    logic             in_data;
    logic [7:0]       val;
    logic [2:0]       addr_lane;
    logic [1:0]       id_lane;
    t_tag             tag;
    logic [7:0]       bcd;
    t_status          st;

    assign data_end  = {1'b0, r_len} + POS_DATA;
    assign seq_pos   = {1'b0, r_len} + POS_LEN;
    assign in_data   = r_started && (r_pos >= POS_DATA) && (r_pos < data_end);
    assign val       = in_data ? (i_rx_byte - DATA_OFFSET) : i_rx_byte;
    assign addr_lane = r_pos[2:0] - 3'd1;
    // data id positions 10..13 map to lanes 0..3
    assign id_lane   = r_pos[1:0] - 2'd2;

    always_comb begin
        n_started  = r_started;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_sum_prev = r_sum_prev;
        n_prev     = r_prev;
        n_hdr_ok   = r_hdr_ok;
        n_close_ok = r_close_ok;
        n_len      = r_len;
        n_ctrl     = r_ctrl;
        n_addr     = r_addr;
        n_id       = r_id;
        n_seq      = r_seq;
        n_err      = r_err;
        n_all_aa   = r_all_aa;
        tag        = TAG_PREAMBLE;
        bcd        = 8'd0;

        if (!r_started) begin
            if (i_rx_byte == START_BYTE) begin
                n_started  = 1'b1;
                tag        = TAG_START;
                n_sum      = i_rx_byte;
                n_sum_prev = 8'd0;
                n_prev     = i_rx_byte;
                n_pos      = 9'd1;
            end
        end else begin
            if (r_pos <= POS_ADDR_LAST) begin
                tag = TAG_ADDR;
                n_addr[8*addr_lane +: 8] = i_rx_byte;
                if (i_rx_byte != ADDR_WILD) begin
                    n_all_aa = 1'b0;
                end
            end else if (r_pos == POS_START2) begin
                tag      = TAG_START2;
                n_hdr_ok = (i_rx_byte == START_BYTE);
            end else if (r_pos == POS_CTRL) begin
                tag    = TAG_CTRL;
                n_ctrl = i_rx_byte;
            end else if (r_pos == POS_LEN) begin
                tag   = TAG_LEN;
                n_len = i_rx_byte;
            end else if (in_data) begin
                if (is_follow(r_ctrl) && (r_pos == seq_pos)) begin
                    tag = TAG_SEQ;
                end else if ((r_pos < POS_ID_END) && has_data_id(r_ctrl)) begin
                    tag = TAG_ID;
                end else begin
                    tag = TAG_DATA;
                end
                if ((r_ctrl == C_TIME) && (r_pos < POS_BCD_END)) begin
                    bcd = ({4'd0, val[7:4]} * 8'd10) + {4'd0, val[3:0]};
                end
            end else begin
                tag = TAG_AFTER;
            end

            if ((r_pos >= POS_DATA) && (r_pos < POS_ID_END)) begin
                n_id[8*id_lane +: 8] = val;
            end
            if (r_pos == POS_DATA) begin
                n_err = val;
            end
            if ((r_pos >= POS_DATA) && (r_pos == seq_pos)) begin
                n_seq = val;
            end
            // position never exceeds the cap, so only the checksum decides
            if ((i_rx_byte == CLOSE_BYTE) && (r_pos >= POS_CLOSE_MIN)) begin
                n_close_ok = (r_prev == r_sum_prev);
            end

            n_sum_prev = r_sum;
            n_sum      = r_sum + i_rx_byte;
            n_prev     = i_rx_byte;
            if (r_pos < POS_CAP) begin
                n_pos = r_pos + 9'd1;
            end
        end

        st = frame_status(n_started && n_hdr_ok && n_close_ok, n_ctrl, n_all_aa, n_err);

        o_result            = '0;
        o_result.byte_value = val;
        o_result.field_tag  = tag;
        o_result.bcd_binary = bcd;
        o_result.status     = ST_REPLY;
        if (i_last) begin
            o_result.frame_done = 1'b1;
            o_result.status     = st;
            if (st != ST_INVALID) begin
                o_result.control_code  = n_ctrl;
                o_result.follow_flag   = n_ctrl[FOLLOW_BIT];
                o_result.meter_address = n_addr;
                if ((st == ST_REPLY) || (st == ST_REPLY_SEQ) || (st == ST_READ) ||
                    (st == ST_WRITE)) begin
                    o_result.data_id = n_id;
                end
                if (st == ST_REPLY_SEQ) begin
                    o_result.sequence_res = n_seq;
                end
                if ((st == ST_NO_ITEM) || (st == ST_OTHER_ERR)) begin
                    o_result.error_byte = n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_started  <= 1'b0;
            r_pos      <= '0;
            r_sum      <= 8'd0;
            r_sum_prev <= 8'd0;
            r_prev     <= 8'd0;
            r_hdr_ok   <= 1'b0;
            r_close_ok <= 1'b0;
            r_len      <= 8'd0;
            r_ctrl     <= 8'd0;
            r_addr     <= 48'd0;
            r_id       <= 32'd0;
            r_seq      <= 8'd0;
            r_err      <= 8'd0;
            r_all_aa   <= 1'b1;
        end else if (i_advance) begin
            r_started  <= n_started;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_sum_prev <= n_sum_prev;
            r_prev     <= n_prev;
            r_hdr_ok   <= n_hdr_ok;
            r_close_ok <= n_close_ok;
            r_len      <= n_len;
            r_ctrl     <= n_ctrl;
            r_addr     <= n_addr;
            r_id       <= n_id;
            r_seq      <= n_seq;
            r_err      <= n_err;
            r_all_aa   <= n_all_aa;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_last |=> !r_started && (r_pos == '0) && r_all_aa)
        else $error("frame state not cleared after last byte");

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_pos == '0))
        else $error("position moved before start byte");

    a_start_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_last && !r_started && (i_rx_byte == START_BYTE) |=>
        r_started && (r_pos == 9'd1))
        else $error("start byte not taken");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.frame_done |-> (o_result.status == ST_REPLY) &&
        (o_result.meter_address == 48'd0))
        else $error("status fields set without frame end");

    a_preamble_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started && (i_rx_byte != START_BYTE) |-> (o_result.field_tag == TAG_PREAMBLE))
        else $error("preamble byte tagged as frame field");

endmodule

[rtl/meter_frame_parser_2007.sv]
// meter frame receiver, one byte per transaction
// input channel: i_valid / o_ready carry i_rx_byte and i_end_of_buffer, the
// flag marks the final byte of a received buffer
// output channel: o_valid / i_ready carry one result per input byte: the byte
// (offset removed inside the data region), its field tag and bcd value; on the
// result of the end-of-buffer byte frame_done is set together with status,
// control code, follow flag, address, data id, sequence and error byte
// a taken byte waits in the input register; its result is loaded into the result
// register when the byte moves on, and is offered from there
// throughput: one byte per cycle while the receiver takes results, set by the
// single pass of parse logic between the input register and the result register
// reset clears the frame state and both valid flags; nothing is offered until a
// byte arrives
// a stalled receiver holds the result register; the input register still takes
// one more byte, then o_ready drops until the result is taken
// after the end-of-buffer byte the parser returns to its reset state at once,
// so the next buffer may follow in the next cycle
module meter_frame_parser_2007 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte_value,
    output logic [3:0]  o_field_tag,
    output logic [7:0]  o_bcd_binary,
    output logic        o_frame_done,
    output logic [3:0]  o_status,
    output logic [7:0]  o_control_code,
    output logic        o_follow_flag,
    output logic [47:0] o_meter_address,
    output logic [31:0] o_data_id,
    output logic [7:0]  o_sequence_res,
    output logic [7:0]  o_error_byte
);
    import mfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       advance;

    // the input item moves on when the result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    mfp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_rx_byte (r_in_byte),
        .i_last    (r_in_last),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_end_of_buffer;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_value    = r_out.byte_value;
    assign o_field_tag     = r_out.field_tag;
    assign o_bcd_binary    = r_out.bcd_binary;
    assign o_frame_done    = r_out.frame_done;
    assign o_status        = r_out.status;
    assign o_control_code  = r_out.control_code;
    assign o_follow_flag   = r_out.follow_flag;
    assign o_meter_address = r_out.meter_address;
    assign o_data_id       = r_out.data_id;
    assign o_sequence_res  = r_out.sequence_res;
    assign o_error_byte    = r_out.error_byte;

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("pending input transaction lost");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed byte produced no result");

endmodule

[verif/meter_frame_parser_2007_tb.sv]
module meter_frame_parser_2007_tb;

    import mfp_pkg::*;

    localparam int BUF_LIMIT    = 512;
    localparam int FLAW_NONE    = 0;
    localparam int FLAW_SUM     = 1;
    localparam int FLAW_HDR     = 2;
    localparam int IDLE_PCT     = 37;
    localparam int RAND_BYTES   = 120;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 400;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int DOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES = 4;

    // expected results of the frame parser, worked out byte by byte
    class parse_board;
        t_result     due_results[$];
        int          errors;
        bit          in_frame;
        bit          hdr_good;
        bit          close_good;
        bit          addr_wild;
        logic [8:0]  pos;
        logic [7:0]  byte_sum;
        logic [7:0]  sum_prior;
        logic [7:0]  last_byte;
        logic [7:0]  len_q;
        logic [7:0]  ctrl_q;
        logic [7:0]  seq_q;
        logic [7:0]  err_q;
        logic [47:0] addr_q;
        logic [31:0] id_q;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_frame   = 1'b0;
            pos        = '0;
            byte_sum   = '0;
            sum_prior  = '0;
            last_byte  = '0;
            hdr_good   = 1'b0;
            close_good = 1'b0;
            len_q      = '0;
            ctrl_q     = '0;
            addr_q     = '0;
            id_q       = '0;
            seq_q      = '0;
            err_q      = '0;
            addr_wild  = 1'b1;
        endfunction

        function void note_byte(input logic [7:0] b, input logic eob);
            t_result    r;
            t_status    st;
            int         p;
            int         dend;
            bit         data_zone;
            logic [7:0] v;
            r = '0;
            v = b;
            r.field_tag = TAG_PREAMBLE;
            if (!in_frame) begin
                if (b == START_BYTE) begin
                    in_frame    = 1'b1;
                    r.field_tag = TAG_START;
                    byte_sum    = b;
                    sum_prior   = '0;
                    last_byte   = b;
                    pos         = 9'd1;
                end
            end else begin
                p = pos;
                dend = 10 + len_q;
                data_zone = (p >= 10) && (p < dend);
                if (data_zone) v = b - DATA_OFFSET;
                if (p <= 6) begin
                    r.field_tag = TAG_ADDR;
                    addr_q[8*(p-1) +: 8] = b;
                    if (b != ADDR_WILD) addr_wild = 1'b0;
                end else if (p == 7) begin
                    r.field_tag = TAG_START2;
                    hdr_good = (b == START_BYTE);
                end else if (p == 8) begin
                    r.field_tag = TAG_CTRL;
                    ctrl_q = b;
                end else if (p == 9) begin
                    r.field_tag = TAG_LEN;
                    len_q = b;
                end else if (data_zone) begin
                    if ((ctrl_q inside {C_FOLLOW_A, C_FOLLOW_B}) && p == dend - 1) begin
                        r.field_tag = TAG_SEQ;
                    end else if (p < 14 && (ctrl_q inside {C_REPLY_A, C_REPLY_B, C_FOLLOW_A,
                                                           C_FOLLOW_B, C_READ, C_WRITE})) begin
                        r.field_tag = TAG_ID;
                    end else begin
                        r.field_tag = TAG_DATA;
                    end
                    if (ctrl_q == C_TIME && p < 16)
                        r.bcd_binary = 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
                end else begin
                    r.field_tag = TAG_AFTER;
                end
                // registers also pick up bytes past the closing byte
                if (p >= 10 && p < 14) id_q[8*(p-10) +: 8] = v;
                if (p == 10) err_q = v;
                if (p >= 10 && p == dend - 1) seq_q = v;
                // every later 0x16 re-decides the close, so the last one wins
                if (b == CLOSE_BYTE && p >= 2)
                    close_good = (p < BUF_LIMIT) && (last_byte == sum_prior);
                sum_prior = byte_sum;
                byte_sum  = byte_sum + b;
                last_byte = b;
                if (pos < POS_CAP) pos = pos + 9'd1;
            end
            r.byte_value = v;
            if (eob) begin
                if (!(in_frame && hdr_good && close_good)) begin
                    st = ST_INVALID;
                end else begin
                    case (ctrl_q)
                        C_REPLY_A, C_REPLY_B:   st = ST_REPLY;
                        C_FOLLOW_A, C_FOLLOW_B: st = ST_REPLY_SEQ;
                        C_READ:                 st = ST_READ;
                        C_SEARCH:               st = addr_wild ? ST_ADDR_SEARCH : ST_CTRL13;
                        C_TIME:                 st = ST_TIME;
                        C_WRITE:                st = ST_WRITE;
                        C_ABN_A, C_ABN_B:       st = (err_q == ERR_NO_ITEM) ? ST_NO_ITEM
                                                                             : ST_OTHER_ERR;
                        default:                st = ST_UNSUPPORTED;
                    endcase
                end
                r.frame_done = 1'b1;
                r.status = st;
                if (st != ST_INVALID) begin
                    r.control_code  = ctrl_q;
                    r.follow_flag   = ctrl_q[FOLLOW_BIT];
                    r.meter_address = addr_q;
                    if (st inside {ST_REPLY, ST_REPLY_SEQ, ST_READ, ST_WRITE}) r.data_id = id_q;
                    if (st == ST_REPLY_SEQ) r.sequence_res = seq_q;
                    if (st inside {ST_NO_ITEM, ST_OTHER_ERR}) r.error_byte = err_q;
                end
                restart();
            end
            due_results.push_back(r);
        endfunction

        function void match_field(input string fld, input logic [63:0] want,
                                  input logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result expected none actual byte %0h tag %0d",
                         $time, got.byte_value, got.field_tag);
                errors++;
                return;
            end
            want = due_results.pop_front();
            match_field("byte_value",    want.byte_value,    got.byte_value);
            match_field("field_tag",     want.field_tag,     got.field_tag);
            match_field("bcd_binary",    want.bcd_binary,    got.bcd_binary);
            match_field("frame_done",    want.frame_done,    got.frame_done);
            match_field("status",        want.status,        got.status);
            match_field("control_code",  want.control_code,  got.control_code);
            match_field("follow_flag",   want.follow_flag,   got.follow_flag);
            match_field("meter_address", want.meter_address, got.meter_address);
            match_field("data_id",       want.data_id,       got.data_id);
            match_field("sequence_res",  want.sequence_res,  got.sequence_res);
            match_field("error_byte",    want.error_byte,    got.error_byte);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        i_end_of_buffer = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_byte_value;
    logic [3:0]  o_field_tag;
    logic [7:0]  o_bcd_binary;
    logic        o_frame_done;
    logic [3:0]  o_status;
    logic [7:0]  o_control_code;
    logic        o_follow_flag;
    logic [47:0] o_meter_address;
    logic [31:0] o_data_id;
    logic [7:0]  o_sequence_res;
    logic [7:0]  o_error_byte;

    parse_board board = new();
    logic [7:0] buf_q[$];
    logic [7:0] payload_q[$];
    int         bytes_in = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;
    bit         hold_done = 1'b0;
    t_result    seen;

    meter_frame_parser_2007 DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_value    (o_byte_value),
        .o_field_tag     (o_field_tag),
        .o_bcd_binary    (o_bcd_binary),
        .o_frame_done    (o_frame_done),
        .o_status        (o_status),
        .o_control_code  (o_control_code),
        .o_follow_flag   (o_follow_flag),
        .o_meter_address (o_meter_address),
        .o_data_id       (o_data_id),
        .o_sequence_res  (o_sequence_res),
        .o_error_byte    (o_error_byte)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] not_start();
        logic [7:0] b;
        do b = 8'($urandom); while (b == START_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] pick_ctrl();
        case ($urandom_range(0, 11))
            0:       return C_REPLY_A;
            1:       return C_REPLY_B;
            2:       return C_FOLLOW_A;
            3:       return C_FOLLOW_B;
            4:       return C_READ;
            5:       return C_SEARCH;
            6:       return C_TIME;
            7:       return C_WRITE;
            8:       return C_ABN_A;
            9:       return C_ABN_B;
            default: return 8'($urandom);
        endcase
    endfunction

    // appends one frame around payload_q, data carried with the 0x33 offset
    function automatic void put_frame(input logic [7:0] ctrl, input logic [47:0] addr,
                                      input int flaw);
        int         at;
        logic [7:0] sum;
        at = buf_q.size();
        sum = '0;
        buf_q.push_back(START_BYTE);
        for (int i = 0; i < 6; i++) buf_q.push_back(addr[8*i +: 8]);
        buf_q.push_back(flaw == FLAW_HDR ? START_BYTE ^ 8'($urandom_range(1, 255)) : START_BYTE);
        buf_q.push_back(ctrl);
        buf_q.push_back(8'(payload_q.size()));
        foreach (payload_q[i]) buf_q.push_back(payload_q[i] + DATA_OFFSET);
        for (int i = at; i < buf_q.size(); i++) sum = sum + buf_q[i];
        buf_q.push_back(flaw == FLAW_SUM ? sum + 8'($urandom_range(1, 255)) : sum);
        buf_q.push_back(CLOSE_BYTE);
    endfunction

    function automatic void add_random_frame(input int flaw);
        logic [7:0]  ctrl;
        logic [47:0] addr;
        int          len;
        ctrl = pick_ctrl();
        addr = {16'($urandom), 32'($urandom)};
        if (ctrl == C_SEARCH && $urandom_range(0, 1)) addr = {6{ADDR_WILD}};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        payload_q.delete();
        repeat (len) payload_q.push_back(8'($urandom));
        if ((ctrl == C_ABN_A || ctrl == C_ABN_B) && len > 0 && $urandom_range(0, 1))
            payload_q[0] = ERR_NO_ITEM;
        put_frame(ctrl, addr, flaw);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eob);
        @(negedge i_clk);
        calm = (bytes_in >= CALM_FROM) && (bytes_in < CALM_TO);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_rx_byte       <= b;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_byte(b, eob);
        bytes_in++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++) push_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    // receiver: random stalls, one long hold-off so the input side backs up
    initial begin
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.byte_value    = o_byte_value;
            seen.field_tag     = t_tag'(o_field_tag);
            seen.bcd_binary    = o_bcd_binary;
            seen.frame_done    = o_frame_done;
            seen.status        = t_status'(o_status);
            seen.control_code  = o_control_code;
            seen.follow_flag   = o_follow_flag;
            seen.meter_address = o_meter_address;
            seen.data_id       = o_data_id;
            seen.sequence_res  = o_sequence_res;
            seen.error_byte    = o_error_byte;
            board.check_result(seen);
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= DOG_LIMIT) begin
                    $display("FAIL meter_frame_parser_2007");
                    $finish;
                end
            end
        end
    end

    initial begin
        int goal;
        int roll;
        int keep;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lone zero byte, no start byte anywhere
        buf_q.push_back(8'h00);
        send_buffer();

        // preamble holding 0x16 and 0xff, then a read request with extreme ids
        buf_q.push_back(8'hFE);
        buf_q.push_back(CLOSE_BYTE);
        buf_q.push_back(8'hFF);
        payload_q.delete();
        payload_q.push_back(8'h00);
        payload_q.push_back(8'hFF);
        payload_q.push_back(8'h00);
        payload_q.push_back(8'hFF);
        put_frame(C_READ, 48'h0, FLAW_NONE);
        send_buffer();

        // follow reply with empty data and trailing bytes after the close
        payload_q.delete();
        put_frame(C_FOLLOW_B, {48{1'b1}}, FLAW_NONE);
        buf_q.push_back(ADDR_WILD);
        buf_q.push_back(DATA_OFFSET);
        send_buffer();

        goal = bytes_in + RAND_BYTES;
        while (bytes_in < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) buf_q.push_back(not_start());
                add_random_frame(roll < 70 ? FLAW_NONE : (roll < 75 ? FLAW_SUM : FLAW_HDR));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom));
            end else if (roll < 90) begin
                repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
            end else begin
                // buffer cut off somewhere inside a frame
                add_random_frame(FLAW_NONE);
                keep = $urandom_range(1, buf_q.size() - 1);
                while (buf_q.size() > keep) void'(buf_q.pop_back());
            end
            send_buffer();
        end

        // longest data region plus enough tail to saturate the position counter
        payload_q.delete();
        repeat (255) payload_q.push_back(8'($urandom));
        put_frame(C_REPLY_B, {16'($urandom), 32'($urandom)}, FLAW_NONE);
        repeat (250) buf_q.push_back(8'($urandom));
        send_buffer();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS meter_frame_parser_2007");
        end else begin
            $display("FAIL meter_frame_parser_2007");
        end
        $finish;
    end

endmodule

[meter_frame_parser_2007.f]
rtl/mfp_pkg.sv
rtl/mfp_core.sv
rtl/meter_frame_parser_2007.sv
verif/meter_frame_parser_2007_tb.sv
